// ----- src/sma_pkg.sv -----
// ----------------------------------------------------------------------------
// sma_pkg: shared types and constants of the stack machine ALU
// Operation codes, field widths, stream widths and the controller state type.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int DATA_W              = 64;
  localparam int HALF_W              = 32;
  localparam int MODE_W              = 5;
  localparam int OUT_CNT_W           = 11;
  localparam int IN_TDATA_W          = 64;
  localparam int OUT_TDATA_W         = 80;
  localparam int DEFAULT_STACK_DEPTH = 1024;

  // Operation codes carried in the request's mode field.
  localparam logic [MODE_W-1:0] MODE_PUSH = 5'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 5'd1;
  localparam logic [MODE_W-1:0] MODE_ADD  = 5'd2;
  localparam logic [MODE_W-1:0] MODE_SUB  = 5'd3;
  localparam logic [MODE_W-1:0] MODE_MUL  = 5'd4;
  localparam logic [MODE_W-1:0] MODE_AND  = 5'd5;
  localparam logic [MODE_W-1:0] MODE_OR   = 5'd6;
  localparam logic [MODE_W-1:0] MODE_XOR  = 5'd7;
  localparam logic [MODE_W-1:0] MODE_SHL  = 5'd8;
  localparam logic [MODE_W-1:0] MODE_SHR  = 5'd9;
  localparam logic [MODE_W-1:0] MODE_EQ   = 5'd10;
  localparam logic [MODE_W-1:0] MODE_NE   = 5'd11;
  localparam logic [MODE_W-1:0] MODE_LT   = 5'd12;
  localparam logic [MODE_W-1:0] MODE_LE   = 5'd13;
  localparam logic [MODE_W-1:0] MODE_GT   = 5'd14;
  localparam logic [MODE_W-1:0] MODE_GE   = 5'd15;
  localparam logic [MODE_W-1:0] MODE_NOT  = 5'd16;
  localparam logic [MODE_W-1:0] MODE_LNOT = 5'd17;
  localparam logic [MODE_W-1:0] MODE_NEG  = 5'd18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELOAD,
    ST_FETCH,
    ST_MUL,
    ST_EXEC
  } state_t;

endpackage

// ----- src/sma_ram.sv -----
// ----------------------------------------------------------------------------
// sma_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sma_alu.sv -----
// ----------------------------------------------------------------------------
// sma_alu: combinational operation unit
// Binary operations other than multiply, and the three unary operations.
// ----------------------------------------------------------------------------
module sma_alu (
  input  logic [sma_pkg::MODE_W-1:0] mode,
  input  logic [sma_pkg::DATA_W-1:0] a,
  input  logic [sma_pkg::DATA_W-1:0] b,
  output logic [sma_pkg::DATA_W-1:0] y
);

  logic       lt_ab;
  logic       lt_ba;
  logic [5:0] shamt;

  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);
  // Only the low six bits of the count are used.
  assign shamt = b[5:0];

  always_comb begin
    case (mode)
      sma_pkg::MODE_ADD:  y = a + b;
      sma_pkg::MODE_SUB:  y = a - b;
      sma_pkg::MODE_AND:  y = a & b;
      sma_pkg::MODE_OR:   y = a | b;
      sma_pkg::MODE_XOR:  y = a ^ b;
      sma_pkg::MODE_SHL:  y = a << shamt;
      sma_pkg::MODE_SHR:  y = a >> shamt;
      sma_pkg::MODE_EQ:   y = sma_pkg::DATA_W'(a == b);
      sma_pkg::MODE_NE:   y = sma_pkg::DATA_W'(a != b);
      sma_pkg::MODE_LT:   y = sma_pkg::DATA_W'(lt_ab);
      sma_pkg::MODE_LE:   y = sma_pkg::DATA_W'(!lt_ba);
      sma_pkg::MODE_GT:   y = sma_pkg::DATA_W'(lt_ba);
      sma_pkg::MODE_GE:   y = sma_pkg::DATA_W'(!lt_ab);
      sma_pkg::MODE_NOT:  y = ~a;
      sma_pkg::MODE_LNOT: y = sma_pkg::DATA_W'(a == '0);
      sma_pkg::MODE_NEG:  y = '0 - a;
      default:            y = '0;
    endcase
  end

endmodule

// ----- src/sma_mul.sv -----
// ----------------------------------------------------------------------------
// sma_mul: iterative 64-bit wrapping multiplier
// One shared 32x32 multiplier over four steps builds the low 64 product bits.
// ----------------------------------------------------------------------------
module sma_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sma_pkg::DATA_W-1:0] a,
  input  logic [sma_pkg::DATA_W-1:0] b,
  output logic                       done,
  output logic [sma_pkg::DATA_W-1:0] product
);

  localparam int HW = sma_pkg::HALF_W;

  logic                       busy_r, busy_nxt;
  logic [1:0]                 step_r, step_nxt;
  logic                       done_r, done_nxt;
  logic [sma_pkg::DATA_W-1:0] prod_r, prod_nxt;
  logic [sma_pkg::DATA_W-1:0] acc_r, acc_nxt;
  logic [HW-1:0]              mul_x;
  logic [HW-1:0]              mul_y;

  // Step 0: lo*lo, step 1: a lo * b hi, step 2: a hi * b lo. The cross
  // products only reach the upper half, and their own upper halves fall off.
  always_comb begin
    mul_x = a[HW-1:0];
    mul_y = b[HW-1:0];
    case (step_r)
      2'd1: mul_y = b[2*HW-1:HW];
      2'd2: mul_x = a[2*HW-1:HW];
      default: ;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
    end else if (busy_r) begin
      prod_nxt = mul_x * mul_y;
      case (step_r) inside
        2'd1: acc_nxt = prod_r;
        [2'd2:2'd3]: acc_nxt = {acc_r[2*HW-1:HW] + prod_r[HW-1:0], acc_r[HW-1:0]};
        default: ;
      endcase
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ----- src/stack_machine_alu.sv -----
// ----------------------------------------------------------------------------
// stack_machine_alu: 64-bit integer value stack with an operation unit
// Pushes, pops and runs arithmetic, logic and compare operations on the stack.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ stream: in_tuser carries the operation code
//   and in_tdata the value for a push. Every request yields exactly one
//   response on the out_ stream with the result value, the sticky halted
//   flag and the number of entries held afterwards.
//   The stack lives in a single-port-read, single-port-write RAM. The top
//   entry is also mirrored in a register, so push, unary operations and
//   pops of the last entry complete without leaving the idle state. A pop
//   that exposes an older entry passes through a reload state, where the
//   RAM read refreshes the top register. A binary operation steps through
//   accept, RAM read of the second entry, execute and write back; multiply
//   adds a state for its four steps on the shared 32x32 multiplier.
//   The response is registered; the response appears the cycle after the
//   result is known. A new request is taken while that response is still
//   being offered, as long as the output register frees up in that cycle.
//   When the receiver stalls, the response is held and no further request
//   is accepted until it has been taken.
//   Reset empties the stack and clears the halted flag; there is no clearing
//   pass since entries above the count are never read. Once halted, every
//   request is answered with a zero value and the unchanged count.
// ----------------------------------------------------------------------------
module stack_machine_alu #(
  parameter int STACK_DEPTH = sma_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sma_pkg::IN_TDATA_W-1:0]  in_tdata,  // [63:0] push_value
  input  logic [sma_pkg::MODE_W-1:0]      in_tuser,  // [4:0] mode
  // Response stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sma_pkg::OUT_TDATA_W-1:0] out_tdata  // [63:0] result_value,
                                                     // [64] halted,
                                                     // [75:65] entry_count,
                                                     // [79:76] zero
);

  localparam int DW    = sma_pkg::DATA_W;
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int OCW   = sma_pkg::OUT_CNT_W;

  sma_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      halt_r, halt_nxt;
  logic [DW-1:0]             tos_r, tos_nxt;
  logic [DW-1:0]             a_r, a_nxt;
  logic [DW-1:0]             b_r, b_nxt;
  logic [sma_pkg::MODE_W-1:0] mode_r, mode_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [DW-1:0]             out_value_r, out_value_nxt;
  logic                      out_halt_r, out_halt_nxt;
  logic [OCW-1:0]            out_count_r, out_count_nxt;

  logic                      out_free;
  logic                      in_fire;
  logic [CNT_W-1:0]          cnt_m1;
  logic [CNT_W-1:0]          cnt_m2;
  logic [OCW+CNT_W-1:0]      count_wide;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [DW-1:0]             mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [DW-1:0]             mem_rdata;

  logic [sma_pkg::MODE_W-1:0] alu_mode;
  logic [DW-1:0]             alu_a;
  logic [DW-1:0]             alu_y;
  logic                      mul_start;
  logic                      mul_done;
  logic [DW-1:0]             mul_y;

  logic                      emit;
  logic [DW-1:0]             res;

  // --------------------------------------------------------------------------
  // Stack storage and operation units
  // --------------------------------------------------------------------------
  sma_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Unary operations work on the mirrored top entry at accept time; binary
  // operations use the captured operands in the execute state.
  assign alu_mode = (state_r == sma_pkg::ST_EXEC) ? mode_r : in_tuser;
  assign alu_a    = (state_r == sma_pkg::ST_EXEC) ? a_r : tos_r;

  sma_alu u_alu (
    .mode (alu_mode),
    .a    (alu_a),
    .b    (b_r),
    .y    (alu_y)
  );

  sma_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (a_r),
    .b       (b_r),
    .done    (mul_done),
    .product (mul_y)
  );

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == sma_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cnt_m1    = count_r - CNT_W'(1);
  assign cnt_m2    = count_r - CNT_W'(2);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    halt_nxt  = halt_r;
    tos_nxt   = tos_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    mode_nxt  = mode_r;
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = in_tdata;
    mem_re    = 1'b0;
    mem_raddr = cnt_m2[AW-1:0];
    mul_start = 1'b0;
    emit      = 1'b0;
    res       = '0;

    unique case (state_r)
      sma_pkg::ST_IDLE: begin
        if (in_fire) begin
          emit = 1'b1;
          if (!halt_r) begin
            unique case (in_tuser) inside
              sma_pkg::MODE_PUSH: begin
                if (count_r == CNT_W'(STACK_DEPTH)) begin
                  halt_nxt = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = count_r[AW-1:0];
                  mem_wdata = in_tdata;
                  tos_nxt   = in_tdata;
                  count_nxt = count_r + CNT_W'(1);
                end
              end
              sma_pkg::MODE_POP: begin
                if (count_r == '0) begin
                  halt_nxt = 1'b1;
                end else begin
                  res       = tos_r;
                  count_nxt = cnt_m1;
                  // Refresh the top register from the entry now exposed.
                  if (count_r >= CNT_W'(2)) begin
                    mem_re    = 1'b1;
                    state_nxt = sma_pkg::ST_RELOAD;
                  end
                end
              end
              [sma_pkg::MODE_ADD:sma_pkg::MODE_GE]: begin
                if (count_r < CNT_W'(2)) begin
                  halt_nxt = 1'b1;
                end else begin
                  emit      = 1'b0;
                  mem_re    = 1'b1;
                  b_nxt     = tos_r;
                  mode_nxt  = in_tuser;
                  count_nxt = cnt_m1;
                  state_nxt = sma_pkg::ST_FETCH;
                end
              end
              [sma_pkg::MODE_NOT:sma_pkg::MODE_NEG]: begin
                if (count_r == '0) begin
                  halt_nxt = 1'b1;
                end else begin
                  res       = alu_y;
                  mem_we    = 1'b1;
                  mem_waddr = cnt_m1[AW-1:0];
                  mem_wdata = alu_y;
                  tos_nxt   = alu_y;
                end
              end
              default: ;
            endcase
          end
        end
      end
      sma_pkg::ST_RELOAD: begin
        tos_nxt   = mem_rdata;
        state_nxt = sma_pkg::ST_IDLE;
      end
      sma_pkg::ST_FETCH: begin
        a_nxt = mem_rdata;
        if (mode_r == sma_pkg::MODE_MUL) begin
          mul_start = 1'b1;
          state_nxt = sma_pkg::ST_MUL;
        end else begin
          state_nxt = sma_pkg::ST_EXEC;
        end
      end
      sma_pkg::ST_MUL: begin
        if (mul_done) begin
          state_nxt = sma_pkg::ST_EXEC;
        end
      end
      sma_pkg::ST_EXEC: begin
        res = (mode_r == sma_pkg::MODE_MUL) ? mul_y : alu_y;
        if (out_free) begin
          // The count was already lowered at accept, so the result replaces
          // the new top entry.
          emit      = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = cnt_m1[AW-1:0];
          mem_wdata = res;
          tos_nxt   = res;
          state_nxt = sma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sma_pkg::ST_IDLE;
    endcase
  end

  // Response register: the entry count is reported modulo 2^11.
  assign count_wide = {{OCW{1'b0}}, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_halt_nxt  = out_halt_r;
    out_count_nxt = out_count_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = res;
      out_halt_nxt  = halt_nxt;
      out_count_nxt = count_wide[OCW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sma_pkg::ST_IDLE;
      count_r     <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tos_r       <= tos_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    mode_r      <= mode_nxt;
    out_value_r <= out_value_nxt;
    out_halt_r  <= out_halt_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sma_pkg::OUT_TDATA_W - DW - 1 - OCW){1'b0}},
                       out_count_r, out_halt_r, out_value_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count exceeds the stack depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r && $stable(count_r))
    else $error("halted state cleared or stack changed while halted");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("read and write of the same stack entry in one cycle");

  a_fetch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sma_pkg::ST_FETCH || state_r == sma_pkg::ST_RELOAD) |-> $past(mem_re))
    else $error("operand captured without a preceding RAM read");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == sma_pkg::ST_MUL)
    else $error("multiplier finished outside the multiply state");

endmodule
